>>> sv/pcq_pkg.sv
// Package for the pose capture qualifier: command, status and register codes,
// the packed layout of input and result items, and reset values.
// No dependencies.
`timescale 1ns / 1ps

package pcq_pkg;

    typedef enum logic [1:0] {
        CMD_START  = 2'd0,
        CMD_SAMPLE = 2'd1,
        CMD_EVENT  = 2'd2,
        CMD_STOP   = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        ST_OK        = 4'd0,
        ST_ALREADY   = 4'd1,
        ST_NOT_REC   = 4'd2,
        ST_TOO_SOON  = 4'd3,
        ST_CAPACITY  = 4'd4,
        ST_INVALID   = 4'd5,
        ST_JUMP      = 4'd6,
        ST_DUPLICATE = 4'd7,
        ST_EMPTY     = 4'd8
    } t_status;

    typedef enum logic [1:0] {
        CFG_POSE_JUMP   = 2'd0,
        CFG_HDG_JUMP    = 2'd1,
        CFG_INVALID_LIM = 2'd2,
        CFG_JUMP_LIM    = 2'd3
    } t_cfg_idx;

    localparam logic [15:0] FULL_TURN     = 16'd36000;
    localparam int          KIND_TABLE    = 16;
    localparam int          KIND_W        = $clog2(KIND_TABLE);
    localparam logic [7:0]  RUN_MAX       = 8'hFF;

    localparam logic [31:0] RST_POSE_SQ   = 32'd1440000;
    localparam logic [14:0] RST_HDG_JUMP  = 15'd4500;
    localparam logic [7:0]  RST_INV_LIM   = 8'd5;
    localparam logic [7:0]  RST_JUMP_LIM  = 8'd3;

    // last field in the lowest bits
    typedef struct packed {
        logic [15:0]        event_value;
        logic [KIND_W-1:0]  event_kind;
        logic [15:0]        heading;
        logic signed [19:0] pos_y;
        logic signed [19:0] pos_x;
        logic               pose_valid;
        logic [31:0]        time_ms;
    } t_in_item;

    typedef struct packed {
        logic [31:0] duration_ms;
        logic [11:0] store_index;
        logic        stored;
        logic        recording;
        t_status     final_status;
        t_status     status;
    } t_out_item;

    localparam int IN_W  = $bits(t_in_item);
    localparam int OUT_W = $bits(t_out_item);

endpackage

>>> sv/pose_capture_qualifier.sv
// Pose capture qualifier top level; uses pcq_pkg.
// Inputs pass through the input register, results through the result register.
// Throughput: one command per cycle when the output is not stalled; all qualification
// is one combinational pass between the two registers, session state updates in that pass.
// Reset (i_rst_n low, synchronous): session idle, counters and runs cleared,
// registers back to defaults; the per-kind last-value table is not cleared.
`timescale 1ns / 1ps

module pose_capture_qualifier
    import pcq_pkg::*;
#(
    parameter int unsigned SAMPLE_SLOTS  = 4096,
    parameter int unsigned EVENT_SLOTS   = 4096,
    parameter int unsigned MIN_PERIOD_MS = 10,
    parameter logic [31:0] MAX_TIME_MS   = 32'd120000,
    parameter int unsigned EVENT_KINDS   = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // time_ms[31:0], pose_valid[32], pos_x[52:33], pos_y[72:53],
    // heading[88:73], event_kind[92:89], event_value[108:93], zero pad above
    input  logic [111:0] s_axis_tdata,
    // command
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[3:0], final_status[7:4], recording[8], stored[9],
    // store_index[21:10], duration_ms[53:22], zero pad above
    output logic [55:0]  m_axis_tdata,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [15:0]  i_cfg_data
);

    localparam int SCNT_W = $clog2(SAMPLE_SLOTS + 1);
    localparam int ECNT_W = $clog2(EVENT_SLOTS + 1);

    // input register
    logic       r_in_vld;
    t_cmd       r_cmd;
    t_in_item   r_in;
    // result register
    logic       r_out_vld;
    t_out_item  r_out;

    // configuration
    logic [31:0] r_pose_sq;
    logic [14:0] r_hdg_jump;
    logic [7:0]  r_inv_lim;
    logic [7:0]  r_jump_lim;

    // session state
    logic               r_active,     n_active;
    t_status            r_result,     n_result;
    logic [31:0]        r_prev_time,  n_prev_time;
    logic               r_prev_valid, n_prev_valid;
    logic signed [19:0] r_prev_x,     n_prev_x;
    logic signed [19:0] r_prev_y,     n_prev_y;
    logic [15:0]        r_prev_hdg,   n_prev_hdg;
    logic [SCNT_W-1:0]  r_samples,    n_samples;
    logic [ECNT_W-1:0]  r_events,     n_events;
    logic [7:0]         r_inv_run,    n_inv_run;
    logic [7:0]         r_jump_run,   n_jump_run;
    logic [31:0]        r_longest,    n_longest;
    logic [KIND_TABLE-1:0] r_seen,    n_seen;
    logic [15:0]        r_last_val [KIND_TABLE];

    logic        adv;
    logic        fire;
    logic        kind_wr;
    t_out_item   n_out;

    logic signed [20:0] dx;
    logic signed [20:0] dy;
    logic signed [41:0] dx_sq;
    logic signed [41:0] dy_sq;
    logic [42:0]        d2;
    logic               pos_jump;
    logic [15:0]        hd;
    logic [15:0]        hm;
    logic [15:0]        he;
    logic [15:0]        gap;
    logic               hdg_jump;
    logic               too_soon;
    logic               tracked;
    logic               dup;
    logic [7:0]         inv_inc;
    logic [7:0]         jump_inc;

    assign adv           = !r_out_vld || m_axis_tready;
    assign fire          = r_in_vld && adv;
    assign s_axis_tready = !r_in_vld || adv;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {{(56 - OUT_W){1'b0}}, r_out};

    // pose and heading step tests, sample timing, duplicate event and run counter checks
    always_comb begin
        dx       = {r_in.pos_x[19], r_in.pos_x} - {r_prev_x[19], r_prev_x};
        dy       = {r_in.pos_y[19], r_in.pos_y} - {r_prev_y[19], r_prev_y};
        dx_sq    = dx * dx;
        dy_sq    = dy * dy;
        d2       = {1'b0, dx_sq} + {1'b0, dy_sq};
        pos_jump = d2 > {11'd0, r_pose_sq};
        hd       = (r_in.heading >= r_prev_hdg) ? r_in.heading - r_prev_hdg
                                                : r_prev_hdg - r_in.heading;
        hm       = (hd >= FULL_TURN) ? hd - FULL_TURN : hd;
        he       = FULL_TURN - hm;
        gap      = (hm < he) ? hm : he;
        hdg_jump = gap > {1'b0, r_hdg_jump};
        too_soon = (r_samples != '0)
                && ((r_in.time_ms < r_prev_time)
                 || ((r_in.time_ms - r_prev_time) < 32'(MIN_PERIOD_MS)));
        tracked  = 32'(r_in.event_kind) < EVENT_KINDS;
        dup      = tracked && r_seen[r_in.event_kind]
                && (r_last_val[r_in.event_kind] == r_in.event_value);
        inv_inc  = (r_inv_run == RUN_MAX) ? RUN_MAX : r_inv_run + 8'd1;
        jump_inc = (r_jump_run == RUN_MAX) ? RUN_MAX : r_jump_run + 8'd1;
    end

    always_comb begin
        n_active     = r_active;
        n_result     = r_result;
        n_prev_time  = r_prev_time;
        n_prev_valid = r_prev_valid;
        n_prev_x     = r_prev_x;
        n_prev_y     = r_prev_y;
        n_prev_hdg   = r_prev_hdg;
        n_samples    = r_samples;
        n_events     = r_events;
        n_inv_run    = r_inv_run;
        n_jump_run   = r_jump_run;
        n_longest    = r_longest;
        n_seen       = r_seen;
        kind_wr      = 1'b0;
        n_out        = '0;
        n_out.status = ST_OK;

        case (r_cmd)
            CMD_START: begin
                if (r_active) begin
                    n_out.status = ST_ALREADY;
                end else begin
                    n_samples    = '0;
                    n_events     = '0;
                    n_longest    = '0;
                    n_seen       = '0;
                    n_prev_time  = '0;
                    n_prev_valid = 1'b0;
                    n_prev_x     = '0;
                    n_prev_y     = '0;
                    n_prev_hdg   = '0;
                    n_inv_run    = '0;
                    n_jump_run   = '0;
                    n_result     = ST_OK;
                    n_active     = 1'b1;
                end
            end
            CMD_SAMPLE: begin
                if (!r_active) begin
                    n_out.status = ST_NOT_REC;
                end else if (too_soon) begin
                    n_out.status = ST_TOO_SOON;
                end else if (r_in.time_ms > MAX_TIME_MS
                          || r_samples >= SCNT_W'(SAMPLE_SLOTS)) begin
                    n_active     = 1'b0;
                    n_result     = ST_CAPACITY;
                    n_out.status = ST_CAPACITY;
                end else begin
                    n_out.stored      = 1'b1;
                    n_out.store_index = 12'(13'(r_samples));
                    n_samples         = r_samples + SCNT_W'(1);
                    n_prev_time       = r_in.time_ms;
                    n_prev_valid      = r_in.pose_valid;
                    n_prev_x          = r_in.pos_x;
                    n_prev_y          = r_in.pos_y;
                    n_prev_hdg        = r_in.heading;
                    if (r_in.time_ms > r_longest) begin
                        n_longest = r_in.time_ms;
                    end
                    if (!r_in.pose_valid) begin
                        n_inv_run  = inv_inc;
                        n_jump_run = '0;
                        if (inv_inc >= r_inv_lim) begin
                            n_active     = 1'b0;
                            n_result     = ST_INVALID;
                            n_out.status = ST_INVALID;
                        end
                    end else begin
                        n_inv_run = '0;
                        if ((r_samples != '0) && r_prev_valid && (pos_jump || hdg_jump)) begin
                            n_jump_run = jump_inc;
                            if (jump_inc >= r_jump_lim) begin
                                n_active     = 1'b0;
                                n_result     = ST_JUMP;
                                n_out.status = ST_JUMP;
                            end
                        end else begin
                            n_jump_run = '0;
                        end
                    end
                end
            end
            CMD_EVENT: begin
                if (!r_active) begin
                    n_out.status = ST_NOT_REC;
                end else if (dup) begin
                    n_out.status = ST_DUPLICATE;
                end else if (r_in.time_ms > MAX_TIME_MS
                          || r_events >= ECNT_W'(EVENT_SLOTS)) begin
                    n_active     = 1'b0;
                    n_result     = ST_CAPACITY;
                    n_out.status = ST_CAPACITY;
                end else begin
                    n_out.stored      = 1'b1;
                    n_out.store_index = 12'(13'(r_events));
                    n_events          = r_events + ECNT_W'(1);
                    if (tracked) begin
                        n_seen[r_in.event_kind] = 1'b1;
                        kind_wr                 = 1'b1;
                    end
                    if (r_in.time_ms > r_longest) begin
                        n_longest = r_in.time_ms;
                    end
                end
            end
            CMD_STOP: begin
                if (!r_active) begin
                    n_out.status = ST_NOT_REC;
                end else begin
                    n_active     = 1'b0;
                    n_result     = (r_samples == '0 && r_events == '0) ? ST_EMPTY : ST_OK;
                    n_out.status = n_result;
                end
            end
            default: begin
                n_out.status = ST_NOT_REC;
            end
        endcase

        n_out.final_status = n_result;
        n_out.recording    = n_active;
        n_out.duration_ms  = n_longest;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                r_in_vld <= 1'b1;
            end else if (fire) begin
                r_in_vld <= 1'b0;
            end
            if (fire) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_cmd <= t_cmd'(s_axis_tuser);
            r_in  <= t_in_item'(s_axis_tdata[IN_W-1:0]);
        end
        if (fire) begin
            r_out <= n_out;
        end
        if (fire && kind_wr) begin
            r_last_val[r_in.event_kind] <= r_in.event_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pose_sq  <= RST_POSE_SQ;
            r_hdg_jump <= RST_HDG_JUMP;
            r_inv_lim  <= RST_INV_LIM;
            r_jump_lim <= RST_JUMP_LIM;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_POSE_JUMP:   r_pose_sq  <= i_cfg_data * i_cfg_data;
                CFG_HDG_JUMP:    r_hdg_jump <= i_cfg_data[14:0];
                CFG_INVALID_LIM: r_inv_lim  <= i_cfg_data[7:0];
                CFG_JUMP_LIM:    r_jump_lim <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active     <= 1'b0;
            r_result     <= ST_OK;
            r_prev_time  <= '0;
            r_prev_valid <= 1'b0;
            r_prev_x     <= '0;
            r_prev_y     <= '0;
            r_prev_hdg   <= '0;
            r_samples    <= '0;
            r_events     <= '0;
            r_inv_run    <= '0;
            r_jump_run   <= '0;
            r_longest    <= '0;
            r_seen       <= '0;
        end else if (fire) begin
            r_active     <= n_active;
            r_result     <= n_result;
            r_prev_time  <= n_prev_time;
            r_prev_valid <= n_prev_valid;
            r_prev_x     <= n_prev_x;
            r_prev_y     <= n_prev_y;
            r_prev_hdg   <= n_prev_hdg;
            r_samples    <= n_samples;
            r_events     <= n_events;
            r_inv_run    <= n_inv_run;
            r_jump_run   <= n_jump_run;
            r_longest    <= n_longest;
            r_seen       <= n_seen;
        end
    end

`ifndef SYNTH
    a_stored_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out.stored |->
            (r_out.status == ST_OK || r_out.status == ST_INVALID
             || r_out.status == ST_JUMP))
        else $error("stored result carries a rejecting status");

    a_not_rec_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out.status == ST_NOT_REC |-> !r_out.recording && !r_out.stored)
        else $error("not-recording result shows activity");

    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_active) |-> r_samples == '0 && r_events == '0 && r_seen == '0
                            && r_longest == '0)
        else $error("session started with stale counts");

    a_recording_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> r_out.recording == r_active && r_out.final_status == r_result)
        else $error("result does not match session state");
`endif

endmodule
